[rtl/core/rpht_pkg.sv]
// Shared types and constants for the recent peer history table.
// No dependencies; rpht_if and the top level refer to this package, rpht_ram does not.
package rpht_pkg;

    localparam int ENTRIES  = 16;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int CMP_W    = (CNT_W > 4) ? CNT_W : 4;
    localparam int KEY_W    = 64;
    localparam int AGE_W    = 32;
    localparam int FRIEND_W = 3;
    localparam int FLAGS_W  = 8;
    localparam int POS_W    = 4;
    localparam int SLOT_W   = 4;
    localparam int ACTIVE_W = 5;
    localparam int CFG_W    = 8;

    localparam logic CFG_ONLINE_MODE = 1'b0;
    localparam logic CFG_MUTE_MASK   = 1'b1;

    typedef enum logic [2:0] {
        OP_INSERT     = 3'd0,
        OP_INVALIDATE = 3'd1,
        OP_SELECT     = 3'd2,
        OP_TOGGLE     = 3'd3,
        OP_CLEAR      = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_WRITE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [AGE_W-1:0]    age;
        logic [FRIEND_W-1:0] friend_code;
        logic [FLAGS_W-1:0]  flags;
    } t_entry;

    typedef struct packed {
        logic                found;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_W-1:0]    slot_key;
        logic [FRIEND_W-1:0] slot_friend;
        logic [FLAGS_W-1:0]  slot_flags;
        logic [ACTIVE_W-1:0] active_count;
    } t_result;

endpackage

[rtl/core/rpht_if.sv]
// Request and response channel interfaces of the peer history table.
// Depends on rpht_pkg for field widths.
interface rpht_req_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    opcode;
    logic [rpht_pkg::KEY_W-1:0]    peer_key;
    logic [rpht_pkg::POS_W-1:0]    position;
    logic                          has_info;
    logic [rpht_pkg::FRIEND_W-1:0] friend_code;
    logic [rpht_pkg::FLAGS_W-1:0]  peer_flags;

    modport source (output valid, opcode, peer_key, position, has_info, friend_code,
                    peer_flags, input ready);
    modport sink   (input valid, opcode, peer_key, position, has_info, friend_code,
                    peer_flags, output ready);
endinterface

interface rpht_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [rpht_pkg::SLOT_W-1:0]   slot;
    logic [rpht_pkg::KEY_W-1:0]    slot_key;
    logic [rpht_pkg::FRIEND_W-1:0] slot_friend;
    logic [rpht_pkg::FLAGS_W-1:0]  slot_flags;
    logic [rpht_pkg::ACTIVE_W-1:0] active_count;

    modport source (output valid, found, slot, slot_key, slot_friend, slot_flags,
                    active_count, input ready);
    modport sink   (input valid, found, slot, slot_key, slot_friend, slot_flags,
                    active_count, output ready);
endinterface

[rtl/core/rpht_ram.sv]
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data. No dependencies.
module rpht_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/core/recent_peer_history_table.sv]
// Top level of the recent peer history table: sequencer, scan logic, flags.
// Depends on rpht_pkg, rpht_req_if / rpht_rsp_if and rpht_ram.
//
//  channel   dir  handshake     beat contents
//  i_req     in   valid/ready   opcode, peer_key, position, has_info, friend_code, peer_flags
//  o_rsp     out  valid/ready   found, slot, slot_key, slot_friend, slot_flags, active_count
//  i_cfg_*   in   write enable  register index, data (online_mode, mute_mask)
//
// Each table operation sweeps the entry RAM through its single read port, one entry
// a cycle: insert, invalidate, select and toggle pass through scan, last, write and
// finish; clear and unused opcodes go straight from idle to write and finish.
// Synchronous active-low reset clears valid and written bits, the stamp and the
// counters at once; the RAM itself is never swept (unwritten entries read as zero).
// A stalled response holds in the output register; the next request is taken
// meanwhile and waits in its last state until the register frees.
module recent_peer_history_table (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    rpht_req_if.sink                  i_req,
    rpht_rsp_if.source                o_rsp,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [rpht_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int E  = rpht_pkg::ENTRIES;
    localparam int IW = rpht_pkg::IDX_W;
    localparam int CW = rpht_pkg::CNT_W;
    localparam int MW = rpht_pkg::CMP_W;

    rpht_pkg::t_state  r_state, n_state;

    // configuration
    logic                            r_online;
    logic [rpht_pkg::FLAGS_W-1:0]    r_mask;

    // table flags and counters
    logic [E-1:0]                    r_valid;
    logic [E-1:0]                    r_written;
    logic [CW-1:0]                   r_active;
    logic [rpht_pkg::AGE_W-1:0]      r_stamp;

    // latched request
    rpht_pkg::t_opcode               r_op;
    logic [rpht_pkg::KEY_W-1:0]      r_key;
    logic [rpht_pkg::POS_W-1:0]      r_pos;
    logic                            r_has_info;
    logic [rpht_pkg::FRIEND_W-1:0]   r_fc;
    logic [rpht_pkg::FLAGS_W-1:0]    r_fl;

    // sweep
    logic [IW-1:0]                   r_rd_idx;
    logic [IW-1:0]                   r_chk_idx;
    logic                            r_chk_live;
    logic [CW-1:0]                   r_rank;

    // scan results
    logic                            r_hit;
    logic [IW-1:0]                   r_hit_idx;
    rpht_pkg::t_entry                r_hit_ent;
    logic                            r_free;
    logic [IW-1:0]                   r_free_idx;
    rpht_pkg::t_entry                r_free_ent;
    logic [IW-1:0]                   r_old_idx;
    rpht_pkg::t_entry                r_old_ent;

    // staged result and output register
    rpht_pkg::t_result               r_res, n_res;
    rpht_pkg::t_result               r_rsp;
    logic                            r_rsp_valid;

    // RAM ports
    logic                            ram_we;
    logic [IW-1:0]                   ram_waddr;
    rpht_pkg::t_entry                ram_wdata;
    rpht_pkg::t_entry                ram_rdata;
    rpht_pkg::t_entry                chk_ent;
    logic                            chk_valid;
    logic                            chk_key_eq;

    // write-back decode
    logic                            w_ins;
    logic                            w_tog;
    logic [IW-1:0]                   w_victim;
    rpht_pkg::t_entry                w_vsrc;
    logic [rpht_pkg::FRIEND_W-1:0]   w_fr;
    logic [rpht_pkg::FLAGS_W-1:0]    w_flg;
    logic [rpht_pkg::FLAGS_W-1:0]    w_tfl;
    logic [CW-1:0]                   w_active;

    logic                            req_fire;
    logic                            rsp_load;

    rpht_ram #(
        .DEPTH (E),
        .WIDTH ($bits(rpht_pkg::t_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    // an entry never written since reset or clear reads as all zero
    assign chk_ent    = r_written[r_chk_idx] ? ram_rdata : '0;
    assign chk_valid  = r_valid[r_chk_idx];
    assign chk_key_eq = (chk_ent.key == r_key);

    assign req_fire = i_req.valid && i_req.ready;

    // write-back decode
    always_comb begin
        w_ins    = (r_op == rpht_pkg::OP_INSERT) && !r_hit;
        w_tog    = (r_op == rpht_pkg::OP_TOGGLE) && r_hit;
        w_victim = r_free ? r_free_idx : r_old_idx;
        w_vsrc   = r_free ? r_free_ent : r_old_ent;
        w_fr     = r_has_info ? r_fc : w_vsrc.friend_code;
        w_flg    = r_has_info ? r_fl : w_vsrc.flags;
        if ((r_hit_ent.flags & r_mask) != '0) begin
            w_tfl = r_hit_ent.flags & ~r_mask;
        end else begin
            w_tfl = r_hit_ent.flags | r_mask;
        end
        w_active = (w_ins && r_free) ? r_active + CW'(1) : r_active;

        n_res = '0;
        n_res.active_count = rpht_pkg::ACTIVE_W'(w_active);
        if (w_ins) begin
            n_res.found       = 1'b1;
            n_res.slot        = rpht_pkg::SLOT_W'(w_victim);
            n_res.slot_key    = r_key;
            n_res.slot_friend = w_fr;
            n_res.slot_flags  = w_flg;
        end else if (r_hit && r_op != rpht_pkg::OP_INSERT) begin
            n_res.found       = 1'b1;
            n_res.slot        = rpht_pkg::SLOT_W'(r_hit_idx);
            n_res.slot_key    = r_hit_ent.key;
            n_res.slot_friend = r_hit_ent.friend_code;
            n_res.slot_flags  = w_tog ? w_tfl : r_hit_ent.flags;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rpht_pkg::ST_IDLE: begin
                if (req_fire) begin
                    if (i_req.opcode inside {rpht_pkg::OP_INSERT, rpht_pkg::OP_INVALIDATE,
                                             rpht_pkg::OP_SELECT, rpht_pkg::OP_TOGGLE}) begin
                        n_state = rpht_pkg::ST_SCAN;
                    end else begin
                        n_state = rpht_pkg::ST_WRITE;
                    end
                end
            end
            rpht_pkg::ST_SCAN: begin
                if (r_rd_idx == IW'(E - 1)) begin
                    n_state = rpht_pkg::ST_LAST;
                end
            end
            rpht_pkg::ST_LAST:   n_state = rpht_pkg::ST_WRITE;
            rpht_pkg::ST_WRITE:  n_state = rpht_pkg::ST_FINISH;
            rpht_pkg::ST_FINISH: begin
                if (rsp_load) begin
                    n_state = rpht_pkg::ST_IDLE;
                end
            end
            default: n_state = rpht_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_req.ready = (r_state == rpht_pkg::ST_IDLE);
        rsp_load    = (r_state == rpht_pkg::ST_FINISH) && (!r_rsp_valid || o_rsp.ready);
        ram_we      = (r_state == rpht_pkg::ST_WRITE) && (w_ins || w_tog);
        ram_waddr   = w_ins ? w_victim : r_hit_idx;
        ram_wdata   = r_hit_ent;
        if (w_ins) begin
            ram_wdata.key         = r_key;
            ram_wdata.age         = r_stamp;
            ram_wdata.friend_code = w_fr;
            ram_wdata.flags       = w_flg;
        end else begin
            ram_wdata.flags       = w_tfl;
        end
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.found        = r_rsp.found;
    assign o_rsp.slot         = r_rsp.slot;
    assign o_rsp.slot_key     = r_rsp.slot_key;
    assign o_rsp.slot_friend  = r_rsp.slot_friend;
    assign o_rsp.slot_flags   = r_rsp.slot_flags;
    assign o_rsp.active_count = r_rsp.active_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rpht_pkg::ST_IDLE;
            r_online    <= 1'b0;
            r_mask      <= rpht_pkg::FLAGS_W'(1);
            r_valid     <= '0;
            r_written   <= '0;
            r_active    <= '0;
            r_stamp     <= '0;
            r_chk_live  <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rpht_pkg::CFG_ONLINE_MODE: r_online <= i_cfg_data[0];
                    rpht_pkg::CFG_MUTE_MASK:   r_mask   <= i_cfg_data;
                    default: ;
                endcase
            end

            // accept: latch the request, arm the sweep, clear the table on OP_CLEAR
            if (req_fire) begin
                r_op       <= rpht_pkg::t_opcode'(i_req.opcode);
                r_key      <= i_req.peer_key;
                r_pos      <= i_req.position;
                r_has_info <= i_req.has_info;
                r_fc       <= i_req.friend_code;
                r_fl       <= i_req.peer_flags;
                r_rd_idx   <= '0;
                r_rank     <= '0;
                r_hit      <= 1'b0;
                r_free     <= 1'b0;
                if (i_req.opcode == rpht_pkg::OP_CLEAR) begin
                    r_valid   <= '0;
                    r_written <= '0;
                    r_active  <= '0;
                    r_stamp   <= '0;
                end
            end

            // advance the read address; data for it arrives next cycle
            r_chk_live <= (r_state == rpht_pkg::ST_SCAN);
            r_chk_idx  <= r_rd_idx;
            if (r_state == rpht_pkg::ST_SCAN && r_rd_idx != IW'(E - 1)) begin
                r_rd_idx <= r_rd_idx + IW'(1);
            end

            if (r_chk_live) begin
                case (r_op)
                    rpht_pkg::OP_INSERT: begin
                        if (chk_valid && chk_key_eq) begin
                            r_hit <= 1'b1;
                        end
                        if (!chk_valid && !r_free) begin
                            r_free     <= 1'b1;
                            r_free_idx <= r_chk_idx;
                            r_free_ent <= chk_ent;
                        end
                        // oldest starts at slot 0, strict compare keeps the lowest on ties
                        if (r_chk_idx == '0 || (chk_valid && chk_ent.age < r_old_ent.age)) begin
                            r_old_idx <= r_chk_idx;
                            r_old_ent <= chk_ent;
                        end
                    end
                    rpht_pkg::OP_INVALIDATE: begin
                        if (r_online && chk_valid && chk_key_eq) begin
                            r_valid[r_chk_idx] <= 1'b0;
                            r_active           <= r_active - CW'(1);
                            if (!r_hit) begin
                                r_hit     <= 1'b1;
                                r_hit_idx <= r_chk_idx;
                                r_hit_ent <= chk_ent;
                            end
                        end
                    end
                    rpht_pkg::OP_SELECT: begin
                        if (chk_valid) begin
                            r_rank <= r_rank + CW'(1);
                            if (!r_hit && MW'(r_rank) == MW'(r_pos)) begin
                                r_hit     <= 1'b1;
                                r_hit_idx <= r_chk_idx;
                                r_hit_ent <= chk_ent;
                            end
                        end
                    end
                    rpht_pkg::OP_TOGGLE: begin
                        if (chk_valid && chk_key_eq && MW'(r_chk_idx) == MW'(r_pos)) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_chk_idx;
                            r_hit_ent <= chk_ent;
                        end
                    end
                    default: ;
                endcase
            end

            // write back; the finish and idle states lie between this write and the next sweep, so no forwarding
            if (r_state == rpht_pkg::ST_WRITE) begin
                r_res <= n_res;
                if (w_ins) begin
                    r_valid[w_victim]   <= 1'b1;
                    r_written[w_victim] <= 1'b1;
                    r_active            <= w_active;
                    r_stamp             <= r_stamp + rpht_pkg::AGE_W'(1);
                end
            end

            if (rsp_load) begin
                r_rsp_valid <= 1'b1;
                r_rsp       <= r_res;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active == CW'($countones(r_valid)))
        else $error("active counter out of step with valid bits");

    a_we_only_insert_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_op == rpht_pkg::OP_INSERT || r_op == rpht_pkg::OP_TOGGLE))
        else $error("RAM write on an operation that stores nothing");

    a_check_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_live |-> (r_state == rpht_pkg::ST_SCAN || r_state == rpht_pkg::ST_LAST))
        else $error("read data processed outside the sweep");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && !r_rsp.found) |-> (r_rsp.slot == '0 && r_rsp.slot_key == '0 &&
                                           r_rsp.slot_flags == '0))
        else $error("miss response carries slot contents");

    a_ram_idle_in_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_state == rpht_pkg::ST_FINISH))
        else $error("RAM write not followed by finish");

endmodule
